[rtl/cct_pkg.sv]
// Shared types, command codes and digit helpers for the clock and countdown timer.
// No dependencies; every other file in this block imports it.
package cct_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CmdTick      = 2'd0,
    CmdClock     = 2'd1,
    CmdCountdown = 2'd2,
    CmdHalt      = 2'd3
  } cmd_e;

  // Running mode as shown on active_mode
  typedef enum logic [1:0] {
    RunHalt      = 2'd0,
    RunClock     = 2'd1,
    RunCountdown = 2'd2
  } run_e;

  localparam logic [7:0] TicksPerSecondReset = 8'd125;
  localparam int unsigned DigitW = 4;

  // Time of day held as six decimal digits, HH:MM:SS
  typedef struct packed {
    logic [DigitW-1:0] hour_tens;
    logic [DigitW-1:0] hour_ones;
    logic [DigitW-1:0] minute_tens;
    logic [DigitW-1:0] minute_ones;
    logic [DigitW-1:0] second_tens;
    logic [DigitW-1:0] second_ones;
  } time_t;

  localparam time_t TimeZero = '{default: 4'd0};
  localparam time_t TimeLast = '{
    hour_tens: 4'd2, hour_ones: 4'd3,
    minute_tens: 4'd5, minute_ones: 4'd9,
    second_tens: 4'd5, second_ones: 4'd9
  };

  // Split a value below 60 into tens and ones digits
  function automatic logic [7:0] split_sixty(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    if (v >= 6'd50)      tens = 3'd5;
    else if (v >= 6'd40) tens = 3'd4;
    else if (v >= 6'd30) tens = 3'd3;
    else if (v >= 6'd20) tens = 3'd2;
    else if (v >= 6'd10) tens = 3'd1;
    else                 tens = 3'd0;
    ones = v - (6'(tens) * 6'd10);
    return {1'b0, tens, ones[3:0]};
  endfunction

endpackage

[rtl/cct_time_step.sv]
// One-second step of a six-digit HH:MM:SS count, up with wrap at 23:59:59
// or down with wrap at 00:00:00. Depends on cct_pkg.
module cct_time_step (
  input  cct_pkg::time_t time_i,
  input  logic           down_i,
  output cct_pkg::time_t time_o
);
  import cct_pkg::*;

  logic c_s1, c_s10, c_m1, c_m10;

  always_comb begin
    time_o = time_i;
    if (!down_i) begin
      // Ripple the carry up through the digits
      c_s1  = (time_i.second_ones == 4'd9);
      c_s10 = c_s1 && (time_i.second_tens == 4'd5);
      c_m1  = c_s10 && (time_i.minute_ones == 4'd9);
      c_m10 = c_m1 && (time_i.minute_tens == 4'd5);
      time_o.second_ones = c_s1 ? 4'd0 : time_i.second_ones + 4'd1;
      if (c_s1) time_o.second_tens = c_s10 ? 4'd0 : time_i.second_tens + 4'd1;
      if (c_s10) time_o.minute_ones = c_m1 ? 4'd0 : time_i.minute_ones + 4'd1;
      if (c_m1) time_o.minute_tens = c_m10 ? 4'd0 : time_i.minute_tens + 4'd1;
      if (c_m10) begin
        if (time_i.hour_tens == 4'd2 && time_i.hour_ones == 4'd3) begin
          time_o.hour_tens = 4'd0;
          time_o.hour_ones = 4'd0;
        end else if (time_i.hour_ones == 4'd9) begin
          time_o.hour_ones = 4'd0;
          time_o.hour_tens = time_i.hour_tens + 4'd1;
        end else begin
          time_o.hour_ones = time_i.hour_ones + 4'd1;
        end
      end
    end else begin
      // Ripple the borrow; all zeros wraps to the last second of the day
      c_s1  = (time_i.second_ones == 4'd0);
      c_s10 = c_s1 && (time_i.second_tens == 4'd0);
      c_m1  = c_s10 && (time_i.minute_ones == 4'd0);
      c_m10 = c_m1 && (time_i.minute_tens == 4'd0);
      if (time_i == TimeZero) begin
        time_o = TimeLast;
      end else begin
        time_o.second_ones = c_s1 ? 4'd9 : time_i.second_ones - 4'd1;
        if (c_s1) time_o.second_tens = c_s10 ? 4'd5 : time_i.second_tens - 4'd1;
        if (c_s10) time_o.minute_ones = c_m1 ? 4'd9 : time_i.minute_ones - 4'd1;
        if (c_m1) time_o.minute_tens = c_m10 ? 4'd5 : time_i.minute_tens - 4'd1;
        if (c_m10) begin
          if (time_i.hour_ones == 4'd0) begin
            time_o.hour_ones = 4'd9;
            time_o.hour_tens = time_i.hour_tens - 4'd1;
          end else begin
            time_o.hour_ones = time_i.hour_ones - 4'd1;
          end
        end
      end
    end
  end

endmodule

[rtl/cct_preset_conv.sv]
// Normalizes six entered digits (each 0..15) into HH:MM:SS, clamped to 23:59:59.
// Depends on cct_pkg.
module cct_preset_conv (
  input  cct_pkg::time_t entry_i,
  output cct_pkg::time_t time_o
);
  import cct_pkg::*;

  logic [7:0] sec_raw, min_raw, hour_raw;
  logic [5:0] sec_n, min_n;
  logic [1:0] sec_carry, min_carry;
  logic [7:0] sec_split, min_split;
  logic [4:0] hour_n;

  always_comb begin
    // Seconds field, up to 165: fold whole minutes into the carry
    sec_raw = 8'(entry_i.second_tens) * 8'd10 + 8'(entry_i.second_ones);
    if (sec_raw >= 8'd120) begin
      sec_carry = 2'd2;
      sec_n     = 6'(sec_raw - 8'd120);
    end else if (sec_raw >= 8'd60) begin
      sec_carry = 2'd1;
      sec_n     = 6'(sec_raw - 8'd60);
    end else begin
      sec_carry = 2'd0;
      sec_n     = sec_raw[5:0];
    end

    // Minutes field plus carry, up to 167
    min_raw = 8'(entry_i.minute_tens) * 8'd10 + 8'(entry_i.minute_ones) + 8'(sec_carry);
    if (min_raw >= 8'd120) begin
      min_carry = 2'd2;
      min_n     = 6'(min_raw - 8'd120);
    end else if (min_raw >= 8'd60) begin
      min_carry = 2'd1;
      min_n     = 6'(min_raw - 8'd60);
    end else begin
      min_carry = 2'd0;
      min_n     = min_raw[5:0];
    end

    hour_raw = 8'(entry_i.hour_tens) * 8'd10 + 8'(entry_i.hour_ones) + 8'(min_carry);
    hour_n   = hour_raw[4:0];

    sec_split = split_sixty(sec_n);
    min_split = split_sixty(min_n);

    // Clamp anything at or beyond a full day
    if (hour_raw >= 8'd24) begin
      time_o = TimeLast;
    end else begin
      time_o.second_tens = sec_split[7:4];
      time_o.second_ones = sec_split[3:0];
      time_o.minute_tens = min_split[7:4];
      time_o.minute_ones = min_split[3:0];
      if (hour_n >= 5'd20) begin
        time_o.hour_tens = 4'd2;
        time_o.hour_ones = 4'(hour_n - 5'd20);
      end else if (hour_n >= 5'd10) begin
        time_o.hour_tens = 4'd1;
        time_o.hour_ones = 4'(hour_n - 5'd10);
      end else begin
        time_o.hour_tens = 4'd0;
        time_o.hour_ones = hour_n[3:0];
      end
    end
  end

endmodule

[rtl/clock_and_countdown_timer.sv]
// HH:MM:SS clock with countdown timer. Each transfer on the input channel is a
// command: tick, select clock, load countdown preset and start, or halt. Every
// command yields exactly one result carrying the six display digits, the running
// mode and a flag that marks a completed second. One command per cycle is taken
// unless a held result stalls; each passes one input register, then prescaler,
// digit counter and preset logic into the state and result registers. Clock and
// countdown keep separate prescalers and counts, held directly as decimal digits
// so no division is needed. ticks_per_second is set via cfg_we_i / cfg_wdata_i
// while idle, a rule for the user that the block does not enforce. Zero makes
// every tick a second. Depends on cct_pkg, cct_time_step and cct_preset_conv.
module clock_and_countdown_timer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic [cct_pkg::DigitW-1:0] preset_hour_tens_i,
  input  logic [cct_pkg::DigitW-1:0] preset_hour_ones_i,
  input  logic [cct_pkg::DigitW-1:0] preset_minute_tens_i,
  input  logic [cct_pkg::DigitW-1:0] preset_minute_ones_i,
  input  logic [cct_pkg::DigitW-1:0] preset_second_tens_i,
  input  logic [cct_pkg::DigitW-1:0] preset_second_ones_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cct_pkg::DigitW-1:0] hour_tens_o,
  output logic [cct_pkg::DigitW-1:0] hour_ones_o,
  output logic [cct_pkg::DigitW-1:0] minute_tens_o,
  output logic [cct_pkg::DigitW-1:0] minute_ones_o,
  output logic [cct_pkg::DigitW-1:0] second_tens_o,
  output logic [cct_pkg::DigitW-1:0] second_ones_o,
  output logic [1:0]                active_mode_o,
  output logic                      second_stepped_o
);
  import cct_pkg::*;

  // Input register
  logic  in_valid_q;
  cmd_e  cmd_q;
  time_t entry_q;

  // State
  logic [7:0] tps_q;
  logic [7:0] clk_pre_q, clk_pre_d;
  logic [7:0] cd_pre_q, cd_pre_d;
  time_t      clk_time_q, clk_time_d;
  time_t      cd_time_q, cd_time_d;
  run_e       run_q, run_d;
  time_t      disp_q, disp_d;

  // Result register
  logic out_valid_q;
  logic stepped_q, stepped_d;

  logic       advance, process;
  logic [8:0] pre_next;
  logic       sec_done;
  time_t      step_in, step_out, preset_time;

  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Step whichever count is running
  assign step_in = (run_q == RunCountdown) ? cd_time_q : clk_time_q;

  cct_time_step u_step (
    .time_i (step_in),
    .down_i (run_q == RunCountdown),
    .time_o (step_out)
  );

  cct_preset_conv u_preset (
    .entry_i (entry_q),
    .time_o  (preset_time)
  );

  // Apply one command to the state
  always_comb begin
    clk_pre_d  = clk_pre_q;
    cd_pre_d   = cd_pre_q;
    clk_time_d = clk_time_q;
    cd_time_d  = cd_time_q;
    run_d      = run_q;
    disp_d     = disp_q;
    stepped_d  = 1'b0;
    pre_next   = (run_q == RunCountdown) ? {1'b0, cd_pre_q} + 9'd1 : {1'b0, clk_pre_q} + 9'd1;
    sec_done   = (pre_next >= {1'b0, tps_q});
    case (cmd_q)
      CmdTick: begin
        if (run_q == RunClock) begin
          clk_pre_d = sec_done ? 8'd0 : pre_next[7:0];
          if (sec_done) begin
            clk_time_d = step_out;
            disp_d     = step_out;
            stepped_d  = 1'b1;
          end
        end else if (run_q == RunCountdown) begin
          cd_pre_d = sec_done ? 8'd0 : pre_next[7:0];
          if (sec_done) begin
            cd_time_d = step_out;
            disp_d    = step_out;
            stepped_d = 1'b1;
          end
        end
      end
      CmdClock: run_d = RunClock;
      CmdCountdown: begin
        cd_time_d = preset_time;
        disp_d    = preset_time;
        run_d     = RunCountdown;
      end
      CmdHalt: run_d = RunHalt;
      default: run_d = run_q;
    endcase
  end

  // Capture the input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q                <= cmd_e'(mode_i);
      entry_q.hour_tens    <= preset_hour_tens_i;
      entry_q.hour_ones    <= preset_hour_ones_i;
      entry_q.minute_tens  <= preset_minute_tens_i;
      entry_q.minute_ones  <= preset_minute_ones_i;
      entry_q.second_tens  <= preset_second_tens_i;
      entry_q.second_ones  <= preset_second_ones_i;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TicksPerSecondReset;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  // Update state and result together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_pre_q   <= 8'd0;
      cd_pre_q    <= 8'd0;
      clk_time_q  <= TimeZero;
      cd_time_q   <= TimeZero;
      run_q       <= RunHalt;
      disp_q      <= TimeZero;
      stepped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (process) begin
        clk_pre_q  <= clk_pre_d;
        cd_pre_q   <= cd_pre_d;
        clk_time_q <= clk_time_d;
        cd_time_q  <= cd_time_d;
        run_q      <= run_d;
        disp_q     <= disp_d;
        stepped_q  <= stepped_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hour_tens_o      = disp_q.hour_tens;
  assign hour_ones_o      = disp_q.hour_ones;
  assign minute_tens_o    = disp_q.minute_tens;
  assign minute_ones_o    = disp_q.minute_ones;
  assign second_tens_o    = disp_q.second_tens;
  assign second_ones_o    = disp_q.second_ones;
  assign active_mode_o    = run_q;
  assign second_stepped_o = stepped_q;

  // A completed second only happens in a running mode
  a_step_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && second_stepped_o |-> active_mode_o != RunHalt)
    else $error("second stepped while halted");

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  // Clock count stays within one day
  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clk_time_q.hour_tens < 4'd2 || (clk_time_q.hour_tens == 4'd2 && clk_time_q.hour_ones <= 4'd3))
    else $error("clock count beyond 23:59:59");

  // Displayed hours never exceed 23
  a_disp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disp_q.hour_tens < 4'd2 || (disp_q.hour_tens == 4'd2 && disp_q.hour_ones <= 4'd3))
    else $error("display beyond 23:59:59");

endmodule
